// ===== hw/rtl/spectrogram_reassign_accumulate_defines.svh =====
// ----------------------------------------------------------------------------
// Spectrogram reassignment accumulator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPECTROGRAM_REASSIGN_ACCUMULATE_DEFINES_SVH
`define SPECTROGRAM_REASSIGN_ACCUMULATE_DEFINES_SVH

// Same-cycle implication.
`define SRAC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRAC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/srac_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectrogram reassignment accumulator package
// Types, codes and helper functions shared by the accumulator modules.
// ----------------------------------------------------------------------------
package srac_pkg;

   localparam int FFT_SIZE_DEF    = 1024;
   localparam int MAX_COLUMNS_DEF = 64;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ACCUM   = 2'd0,
      ST_LOW     = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_READ    = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_REASSIGN_TIME   = 3'd0;
   localparam logic [2:0] CSR_POWER_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_POWER_SHIFT     = 3'd2;
   localparam logic [2:0] CSR_INV_STRIDE      = 3'd3;
   localparam logic [2:0] CSR_COLUMN_COUNT    = 3'd4;

   // Saturation limit of a Q16 ratio.
   localparam logic [30:0] QMAX = '1;

   typedef struct packed {
      logic        reassign_time;
      logic [47:0] power_threshold;
      logic [5:0]  power_shift;
      logic [16:0] inv_stride;
      logic [6:0]  column_count;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef enum logic [3:0] {
      F_IDLE, F_MUL, F_SUM, F_CHK, F_DIV, F_OFS, F_ADJ, F_RND, F_TGT, F_WRAP, F_FIX, F_EMIT
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR, B_IDLE, B_READ, B_MOD
   } back_state_type;

   // Round a signed Q16 value to an integer, ties to even.
   function automatic logic signed [33:0] round_q16(input logic signed [47:0] v);
      logic [47:0] m;
      logic [31:0] ip;
      logic [15:0] fr;
      logic        up;
      logic [32:0] r;
      m  = v[47] ? 48'(-v) : 48'(v);
      ip = m[47:16];
      fr = m[15:0];
      up = (fr > 16'h8000) || ((fr == 16'h8000) && ip[0]);
      r  = {1'b0, ip} + {32'd0, up};
      return v[47] ? -$signed({1'b0, r}) : $signed({1'b0, r});
   endfunction

endpackage

// ===== hw/rtl/srac_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the arithmetic front from the tile back end.
// ----------------------------------------------------------------------------
module srac_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        data_in,
   input  logic                    pop,
   output logic [WIDTH-1:0]        data_out,
   output srac_pkg::fifo_stat_type stat
);
   import srac_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ff, rd_ff;

   // Occupancy flags.
   always_comb begin
      stat.full  = (count_ff == 2'd2);
      stat.empty = (count_ff == 2'd0);
   end

   assign data_out = entry_ff[rd_ff];
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= data_in;
   end

endmodule

// ===== hw/rtl/srac_front.sv =====
// ----------------------------------------------------------------------------
// Reassignment front end
// Accepts transactions, computes power and reassignment targets with a
// bit-serial divider and a reciprocal-multiply bin wrap, and queues tile
// commands.
// ----------------------------------------------------------------------------
module srac_front #(
   parameter int FFT_SIZE    = 1024,
   parameter int MAX_COLUMNS = 64,
   parameter int CMD_W       = 83
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_mode,
   input  logic [5:0]              req_column,
   input  logic [9:0]              req_bin,
   input  logic signed [23:0]      req_h_re,
   input  logic signed [23:0]      req_h_im,
   input  logic signed [23:0]      req_dh_re,
   input  logic signed [23:0]      req_dh_im,
   input  logic signed [23:0]      req_th_re,
   input  logic signed [23:0]      req_th_im,
   input  srac_pkg::cfg_type       cfg,
   input  logic                    clearing,
   input  srac_pkg::fifo_stat_type fifo_stat,
   output logic                    fifo_push,
   output logic [CMD_W-1:0]        fifo_data
);
   import srac_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS * FFT_SIZE);
   localparam longint unsigned FSCALE =
      ((longint'(FFT_SIZE) * 64'd683565276) + 64'd32768) >> 16;
   localparam int FS_W = $clog2(FSCALE + 1);
   localparam int PF_W = 31 + FS_W;
   localparam logic [FS_W-1:0] FSCALE_C = FS_W'(FSCALE);
   // Reciprocal of the transform size, 32 fraction bits, rounded down.
   localparam longint unsigned WRAP_RECIP = 64'h1_0000_0000 / longint'(FFT_SIZE);
   localparam logic [31:0] WRAP_RECIP_C = 32'(WRAP_RECIP);

   front_state_type state_ff, state_in;

   logic [5:0]         col_ff;
   logic [9:0]         bin_ff;
   logic signed [23:0] hr_ff, hi_ff, dr_ff, di_ff, tr_ff, ti_ff;
   logic signed [47:0] pr0_ff, pr1_ff, pr2_ff, pr3_ff, pr4_ff, pr5_ff;
   logic [47:0]        pw_ff;
   logic signed [48:0] a_ff, b_ff;
   logic [63:0]        rem_a_ff, rem_b_ff;
   logic [78:0]        dvs_ff;
   logic [30:0]        qa_ff, qb_ff;
   logic               sat_a_ff, sat_b_ff, neg_a_ff, neg_b_ff;
   logic [5:0]         cnt_ff;
   logic [45:0]        off_ff;
   logic [31:0]        toff_ff;
   logic signed [47:0] f16_ff, t16_ff;
   logic signed [33:0] fr_ff, tc_ff;
   logic               wneg_ff;
   logic [32:0]        wrem_ff;
   logic [31:0]        quo_ff;
   status_type         status_ff;
   logic [5:0]         tcol_ff;
   logic [9:0]         tbin_ff;
   logic               hit_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [47:0]        addp_ff;

   logic               accept, low_power, outside, ge_a, ge_b, rd_ok;
   logic [48:0]        mag_a, mag_b;
   logic [10:0]        cols;
   logic [16:0]        bidx_raw, bidx, ob;
   logic [32:0]        wfix;
   logic [ADDR_W-1:0]  rd_addr, acc_addr;
   logic [30:0]        qa_sel, qb_sel;
   logic [PF_W-1:0]    prod_f;
   logic [47:0]        prod_t;
   logic signed [47:0] fbase, tbase;

   assign accept = req_push && !req_full;

   // Read-mode addressing with the half-size shift.
   always_comb begin
      rd_ok    = (11'(req_column) < 11'(MAX_COLUMNS)) && (17'(req_bin) < 17'(FFT_SIZE));
      bidx_raw = 17'(req_bin) + 17'(FFT_SIZE / 2);
      bidx     = (bidx_raw >= 17'(FFT_SIZE)) ? bidx_raw - 17'(FFT_SIZE) : bidx_raw;
      rd_addr  = ADDR_W'(32'(req_column) * 32'(FFT_SIZE) + 32'(bidx));
   end

   // Threshold test, magnitudes and divider steps.
   always_comb begin
      low_power = (pw_ff == '0) || (pw_ff < cfg.power_threshold);
      mag_a     = a_ff[48] ? 49'(-a_ff) : 49'(a_ff);
      mag_b     = b_ff[48] ? 49'(-b_ff) : 49'(b_ff);
      ge_a      = {15'd0, rem_a_ff} >= dvs_ff;
      ge_b      = {15'd0, rem_b_ff} >= dvs_ff;
   end

   // Offsets from the saturated ratios.
   always_comb begin
      qa_sel = sat_a_ff ? QMAX : qa_ff;
      qb_sel = sat_b_ff ? QMAX : qb_ff;
      prod_f = PF_W'(qa_sel) * PF_W'(FSCALE_C);
      prod_t = 48'(qb_sel) * 48'(cfg.inv_stride);
      fbase  = $signed({22'd0, bin_ff, 16'd0});
      tbase  = $signed({26'd0, col_ff, 16'd0});
   end

   // Target column range and wrapped bin. The estimated remainder is below
   // twice the transform size, so one conditional subtraction finishes it.
   always_comb begin
      cols     = (11'(cfg.column_count) > 11'(MAX_COLUMNS)) ?
                 11'(MAX_COLUMNS) : 11'(cfg.column_count);
      outside  = tc_ff[33] || (tc_ff >= $signed({23'd0, cols}));
      wfix     = (wrem_ff >= 33'(FFT_SIZE)) ? wrem_ff - 33'(FFT_SIZE) : wrem_ff;
      ob       = (wneg_ff && (wfix != '0)) ?
                 17'(FFT_SIZE) - wfix[16:0] : wfix[16:0];
      acc_addr = ADDR_W'(32'(tc_ff[10:0]) * 32'(FFT_SIZE) + 32'(ob));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = req_mode ? F_EMIT : F_MUL;
         F_MUL:  state_in = F_SUM;
         F_SUM:  state_in = F_CHK;
         F_CHK:  state_in = low_power ? F_EMIT : F_DIV;
         F_DIV:  if (cnt_ff == 6'd1) state_in = F_OFS;
         F_OFS:  state_in = F_ADJ;
         F_ADJ:  state_in = F_RND;
         F_RND:  state_in = F_TGT;
         F_TGT:  state_in = outside ? F_EMIT : F_WRAP;
         F_WRAP: if (cnt_ff == 6'd1) state_in = F_FIX;
         F_FIX:  state_in = F_EMIT;
         F_EMIT: if (!fifo_stat.full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_full  = (state_ff != F_IDLE) || clearing;
      fifo_push = (state_ff == F_EMIT) && !fifo_stat.full;
      fifo_data = {status_ff, tcol_ff, tbin_ff, hit_ff, addr_ff, addp_ff};
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath registers, one step per state.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               col_ff    <= req_column;
               bin_ff    <= req_bin;
               hr_ff     <= req_h_re;
               hi_ff     <= req_h_im;
               dr_ff     <= req_dh_re;
               di_ff     <= req_dh_im;
               tr_ff     <= req_th_re;
               ti_ff     <= req_th_im;
               status_ff <= ST_READ;
               tcol_ff   <= rd_ok ? req_column : '0;
               tbin_ff   <= rd_ok ? bidx[9:0] : '0;
               hit_ff    <= rd_ok;
               addr_ff   <= rd_addr;
               addp_ff   <= '0;
            end
         end
         F_MUL: begin
            pr0_ff <= hr_ff * hr_ff;
            pr1_ff <= hi_ff * hi_ff;
            pr2_ff <= di_ff * hr_ff;
            pr3_ff <= dr_ff * hi_ff;
            pr4_ff <= tr_ff * hr_ff;
            pr5_ff <= ti_ff * hi_ff;
         end
         F_SUM: begin
            pw_ff <= 48'(pr0_ff + pr1_ff);
            a_ff  <= 49'(pr2_ff) - 49'(pr3_ff);
            b_ff  <= 49'(pr4_ff) + 49'(pr5_ff);
         end
         F_CHK: begin
            status_ff <= ST_LOW;
            tcol_ff   <= '0;
            tbin_ff   <= '0;
            hit_ff    <= 1'b0;
            addr_ff   <= '0;
            addp_ff   <= pw_ff >> cfg.power_shift;
            rem_a_ff  <= {mag_a[47:0], 16'd0};
            rem_b_ff  <= {mag_b[47:0], 16'd0};
            sat_a_ff  <= {15'd0, mag_a[47:0], 16'd0} >= {pw_ff, 31'd0};
            sat_b_ff  <= {15'd0, mag_b[47:0], 16'd0} >= {pw_ff, 31'd0};
            neg_a_ff  <= a_ff[48];
            neg_b_ff  <= b_ff[48];
            dvs_ff    <= {1'b0, pw_ff, 30'd0};
            qa_ff     <= '0;
            qb_ff     <= '0;
            cnt_ff    <= 6'd31;
         end
         F_DIV: begin
            rem_a_ff <= ge_a ? 64'({15'd0, rem_a_ff} - dvs_ff) : rem_a_ff;
            rem_b_ff <= ge_b ? 64'({15'd0, rem_b_ff} - dvs_ff) : rem_b_ff;
            qa_ff    <= {qa_ff[29:0], ge_a};
            qb_ff    <= {qb_ff[29:0], ge_b};
            dvs_ff   <= dvs_ff >> 1;
            cnt_ff   <= cnt_ff - 6'd1;
         end
         F_OFS: begin
            off_ff  <= 46'(prod_f >> 16);
            toff_ff <= prod_t[47:16];
         end
         F_ADJ: begin
            f16_ff <= neg_a_ff ? fbase + $signed({2'd0, off_ff})
                               : fbase - $signed({2'd0, off_ff});
            if (!cfg.reassign_time) t16_ff <= tbase;
            else if (neg_b_ff)      t16_ff <= tbase - $signed({16'd0, toff_ff});
            else                    t16_ff <= tbase + $signed({16'd0, toff_ff});
         end
         F_RND: begin
            fr_ff <= round_q16(f16_ff);
            tc_ff <= round_q16(t16_ff);
         end
         F_TGT: begin
            status_ff <= ST_OUTSIDE;
            tcol_ff   <= '0;
            tbin_ff   <= '0;
            hit_ff    <= 1'b0;
            addr_ff   <= '0;
            wneg_ff   <= fr_ff[33];
            wrem_ff   <= fr_ff[33] ? 33'(-fr_ff) : 33'(fr_ff);
            cnt_ff    <= 6'd2;
         end
         F_WRAP: begin
            // The rounded bin magnitude stays well below 2^32, so the low
            // 32 bits carry it. First the quotient estimate, then the remainder.
            if (cnt_ff == 6'd2) begin
               quo_ff <= 32'(({32'd0, wrem_ff[31:0]} * {32'd0, WRAP_RECIP_C}) >> 32);
            end else begin
               wrem_ff <= wrem_ff - 33'(64'(quo_ff) * 64'(FFT_SIZE));
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         F_FIX: begin
            status_ff <= ST_ACCUM;
            tcol_ff   <= tc_ff[5:0];
            tbin_ff   <= ob[9:0];
            hit_ff    <= 1'b1;
            addr_ff   <= acc_addr;
         end
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/srac_back.sv =====
// ----------------------------------------------------------------------------
// Tile back end
// Holds the power tile, clears it after reset, and carries out queued
// accumulate and read-and-clear commands by read-modify-write.
// ----------------------------------------------------------------------------
module srac_back #(
   parameter int FFT_SIZE    = 1024,
   parameter int MAX_COLUMNS = 64,
   parameter int CMD_W       = 83
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srac_pkg::fifo_stat_type fifo_stat,
   output logic                    fifo_pop,
   input  logic [CMD_W-1:0]        fifo_data,
   output logic                    clearing,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_target_column,
   output logic [9:0]              rsp_target_bin,
   output logic [47:0]             rsp_power
);
   import srac_pkg::*;

   localparam int DEPTH  = MAX_COLUMNS * FFT_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);

   back_state_type state_ff, state_in;

   logic [47:0]       tile [DEPTH];
   logic [ADDR_W-1:0] clr_ff;
   logic [47:0]       rdata_ff;

   logic [1:0]        c_status;
   logic [5:0]        c_col;
   logic [9:0]        c_bin;
   logic              c_hit;
   logic [ADDR_W-1:0] c_addr;
   logic [47:0]       c_addp;

   status_type        status_ff;
   logic [5:0]        col_ff;
   logic [9:0]        bin_ff;
   logic              hit_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [47:0]       addp_ff;

   logic              out_valid_ff;
   logic [1:0]        out_status_ff;
   logic [5:0]        out_col_ff;
   logic [9:0]        out_bin_ff;
   logic [47:0]       out_power_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [47:0]       mem_wdata;
   logic [48:0]       sum;
   logic [47:0]       sat_sum;

   assign {c_status, c_col, c_bin, c_hit, c_addr, c_addp} = fifo_data;

   // Saturating accumulation.
   always_comb begin
      sum     = {1'b0, rdata_ff} + {1'b0, addp_ff};
      sat_sum = sum[48] ? '1 : sum[47:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = B_IDLE;
         B_IDLE:  if (!fifo_stat.empty && !out_valid_ff) state_in = B_READ;
         B_READ:  state_in = B_MOD;
         B_MOD:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Queue pop and memory write control.
   always_comb begin
      clearing  = (state_ff == B_CLEAR);
      fifo_pop  = (state_ff == B_IDLE) && !fifo_stat.empty && !out_valid_ff;
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      unique case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         B_MOD: begin
            mem_we    = hit_ff;
            mem_wdata = (status_ff == ST_READ) ? '0 : sat_sum;
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == B_MOD)           out_valid_ff <= 1'b1;
         else if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
      end
   end

   // Command capture and result register.
   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         status_ff <= status_type'(c_status);
         col_ff    <= c_col;
         bin_ff    <= c_bin;
         hit_ff    <= c_hit;
         addr_ff   <= c_addr;
         addp_ff   <= c_addp;
      end
      if (state_ff == B_MOD) begin
         out_status_ff <= status_ff;
         out_col_ff    <= col_ff;
         out_bin_ff    <= bin_ff;
         out_power_ff  <= ((status_ff == ST_READ) && hit_ff) ? rdata_ff : '0;
      end
   end

   // Tile memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) tile[mem_waddr] <= mem_wdata;
      rdata_ff <= tile[addr_ff];
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_target_column = out_col_ff;
   assign rsp_target_bin    = out_bin_ff;
   assign rsp_power         = out_power_ff;

endmodule

// ===== hw/rtl/spectrogram_reassign_accumulate.sv =====
// An accumulate transaction passes the front end through the 31-step bit-serial
// divider; a low-power one skips it and a read goes straight to the queue. The back
// end then does the tile read-modify-write before the result appears. The front end
// takes no new transaction until the last is queued, the back end none until its
// result is popped. Reset is synchronous; afterwards, with req_full held high, the
// tile is cleared one entry per cycle, all MAX_COLUMNS*FFT_SIZE (65536 by default).
// ----------------------------------------------------------------------------
// Spectrogram reassignment accumulator
// Reassigns spectrogram bin power in time and frequency into a saturating tile.
// ----------------------------------------------------------------------------
`include "spectrogram_reassign_accumulate_defines.svh"

module spectrogram_reassign_accumulate #(
   parameter int FFT_SIZE    = srac_pkg::FFT_SIZE_DEF,
   parameter int MAX_COLUMNS = srac_pkg::MAX_COLUMNS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic [5:0]         req_column,
   input  logic [9:0]         req_bin,
   input  logic signed [23:0] req_h_re,
   input  logic signed [23:0] req_h_im,
   input  logic signed [23:0] req_dh_re,
   input  logic signed [23:0] req_dh_im,
   input  logic signed [23:0] req_th_re,
   input  logic signed [23:0] req_th_im,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_target_column,
   output logic [9:0]         rsp_target_bin,
   output logic [47:0]        rsp_power,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);
   import srac_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS * FFT_SIZE);
   localparam int CMD_W  = ADDR_W + 67;

   cfg_type          cfg_ff;
   fifo_stat_type    fifo_stat;
   logic             fifo_push, fifo_pop, clearing;
   logic [CMD_W-1:0] fifo_in, fifo_out;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reassign_time   <= 1'b1;
         cfg_ff.power_threshold <= '0;
         cfg_ff.power_shift     <= 6'd20;
         cfg_ff.inv_stride      <= 17'd65536;
         cfg_ff.column_count    <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REASSIGN_TIME:   cfg_ff.reassign_time   <= csr_data[0];
            CSR_POWER_THRESHOLD: cfg_ff.power_threshold <= csr_data[47:0];
            CSR_POWER_SHIFT:     cfg_ff.power_shift     <= csr_data[5:0];
            CSR_INV_STRIDE:      cfg_ff.inv_stride      <= csr_data[16:0];
            CSR_COLUMN_COUNT:    cfg_ff.column_count    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Arithmetic front end.
   srac_front #(
      .FFT_SIZE    (FFT_SIZE),
      .MAX_COLUMNS (MAX_COLUMNS),
      .CMD_W       (CMD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_column (req_column),
      .req_bin    (req_bin),
      .req_h_re   (req_h_re),
      .req_h_im   (req_h_im),
      .req_dh_re  (req_dh_re),
      .req_dh_im  (req_dh_im),
      .req_th_re  (req_th_re),
      .req_th_im  (req_th_im),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .fifo_stat  (fifo_stat),
      .fifo_push  (fifo_push),
      .fifo_data  (fifo_in)
   );

   // Command queue between the two halves.
   srac_fifo #(
      .WIDTH (CMD_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .data_in  (fifo_in),
      .pop      (fifo_pop),
      .data_out (fifo_out),
      .stat     (fifo_stat)
   );

   // Tile back end.
   srac_back #(
      .FFT_SIZE    (FFT_SIZE),
      .MAX_COLUMNS (MAX_COLUMNS),
      .CMD_W       (CMD_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .fifo_stat         (fifo_stat),
      .fifo_pop          (fifo_pop),
      .fifo_data         (fifo_out),
      .clearing          (clearing),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_target_column (rsp_target_column),
      .rsp_target_bin    (rsp_target_bin),
      .rsp_power         (rsp_power)
   );

   // No transaction is taken while the tile is being cleared.
   `SRAC_ASSERT_IMP(a_clear_blocks_input, clearing, req_full, "input accepted during clear")
   // Only read results carry a power value.
   `SRAC_ASSERT_IMP(a_power_only_on_read, !rsp_empty && (rsp_status != ST_READ), rsp_power == '0, "power on non-read result")
   // A queued command is visible to the back end in the next cycle.
   `SRAC_ASSERT_NXT(a_push_fills_queue, fifo_push, !fifo_stat.empty, "queued command lost")

endmodule

// ===== sim/tb_spectrogram_reassign_accumulate.sv =====
// ----------------------------------------------------------------------------
// Spectrogram reassignment accumulator testbench
// Drives accumulate and read-and-clear transactions through several register
// settings, predicts every result and the tile contents, and checks each
// result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_spectrogram_reassign_accumulate;

   import srac_pkg::*;

   localparam int  N_FFT      = 1024;
   localparam int  N_COLS     = 64;
   localparam bit [63:0] FREQ_SCALE = ((64'(N_FFT) * 64'd683565276) + 64'd32768) >> 16;
   localparam bit [63:0] RATIO_MAX  = 64'h7FFF_FFFF;
   localparam bit [47:0] PWR_MAX    = '1;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  SETTLE      = 100;

   typedef struct {
      bit               mode;
      bit [5:0]         column;
      bit [9:0]         bin;
      bit signed [23:0] h_re, h_im, dh_re, dh_im, th_re, th_im;
   } bin_item_type;

   typedef struct {
      status_type status;
      bit [5:0]   column;
      bit [9:0]   bin;
      bit [47:0]  power;
   } tile_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_mode = 1'b0;
   logic [5:0]         req_column = '0;
   logic [9:0]         req_bin = '0;
   logic signed [23:0] req_h_re = '0, req_h_im = '0, req_dh_re = '0;
   logic signed [23:0] req_dh_im = '0, req_th_re = '0, req_th_im = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_target_column;
   logic [9:0]         rsp_target_bin;
   logic [47:0]        rsp_power;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [47:0]        csr_data = '0;

   // Predictor copy of the registers and the tile (unwritten entries are zero).
   bit        m_reassign_time;
   bit [47:0] m_threshold;
   bit [5:0]  m_shift;
   bit [16:0] m_inv_stride;
   bit [6:0]  m_column_count;
   bit [47:0] tile_model [int];

   bin_item_type    pending_bins[$];
   tile_result_type expected_results[$];
   bit              took;
   int              errors, cycles, hold_left;
   int              status_seen[4];
   bit              long_hold_done;

   spectrogram_reassign_accumulate i_dut (.*);

   always #5 clock = ~clock;

   // Round a signed Q16 value to an integer, ties to even.
   function automatic longint round_even(longint v);
      bit [63:0] m;
      bit [63:0] ip;
      m  = v < 0 ? 64'(-v) : 64'(v);
      ip = m >> 16;
      if (m[15:0] > 16'h8000 || (m[15:0] == 16'h8000 && ip[0])) ip++;
      return v < 0 ? -longint'(ip) : longint'(ip);
   endfunction

   function automatic bit [63:0] q16_ratio(bit [63:0] num, bit [63:0] den);
      bit [63:0] q;
      q = (num << 16) / den;
      return q > RATIO_MAX ? RATIO_MAX : q;
   endfunction

   // Work out the result of one transaction and update the tile copy.
   function automatic tile_result_type reassign_bin(bin_item_type it);
      tile_result_type r;
      longint hr, hi, dr, di, tr, ti, a, b, f16, t16, fr, tc;
      bit [63:0] pw, off, toff, sum;
      int idx, cols;
      r = '{ST_ACCUM, '0, '0, '0};
      if (it.mode) begin
         r.status = ST_READ;
         r.column = it.column;
         r.bin    = 10'((int'(it.bin) + N_FFT / 2) % N_FFT);
         idx      = int'(it.column) * N_FFT + int'(r.bin);
         r.power  = tile_model.exists(idx) ? tile_model[idx] : '0;
         tile_model[idx] = '0;
         return r;
      end
      hr = it.h_re;  hi = it.h_im;
      dr = it.dh_re; di = it.dh_im;
      tr = it.th_re; ti = it.th_im;
      pw = 64'(hr * hr + hi * hi);
      if (pw == 0 || pw < 64'(m_threshold)) begin
         r.status = ST_LOW;
         return r;
      end
      a   = di * hr - dr * hi;
      off = (q16_ratio(a < 0 ? 64'(-a) : 64'(a), pw) * FREQ_SCALE) >> 16;
      f16 = longint'(it.bin) <<< 16;
      f16 = a < 0 ? f16 + longint'(off) : f16 - longint'(off);
      t16 = longint'(it.column) <<< 16;
      if (m_reassign_time) begin
         b    = tr * hr + ti * hi;
         toff = (q16_ratio(b < 0 ? 64'(-b) : 64'(b), pw) * 64'(m_inv_stride)) >> 16;
         t16  = b < 0 ? t16 - longint'(toff) : t16 + longint'(toff);
      end
      fr   = round_even(f16);
      tc   = round_even(t16);
      cols = m_column_count > N_COLS ? N_COLS : int'(m_column_count);
      if (tc < 0 || tc >= cols) begin
         r.status = ST_OUTSIDE;
         return r;
      end
      fr = fr % N_FFT;
      if (fr < 0) fr += N_FFT;
      idx = int'(tc) * N_FFT + int'(fr);
      sum = 64'(tile_model.exists(idx) ? tile_model[idx] : 48'd0) + (pw >> m_shift);
      tile_model[idx] = sum > 64'(PWR_MAX) ? PWR_MAX : sum[47:0];
      r.column = 6'(tc);
      r.bin    = 10'(fr);
      return r;
   endfunction

   // A field of random magnitude: full scale or shifted down by a random amount.
   function automatic bit signed [23:0] rand_field();
      bit signed [23:0] v;
      v = 24'($urandom);
      return v >>> $urandom_range(0, 23);
   endfunction

   function automatic bin_item_type random_bin();
      bin_item_type it;
      int sh;
      it.mode   = ($urandom_range(0, 9) < 3);
      it.column = 6'($urandom);
      it.bin    = 10'($urandom);
      sh        = $urandom_range(0, 12);
      it.h_re   = $signed(24'($urandom)) >>> sh;
      it.h_im   = $signed(24'($urandom)) >>> sh;
      // Mostly small derivative terms keep targets near the source bin.
      if ($urandom_range(0, 3) != 0) begin
         it.dh_re = $signed(it.h_im) >>> $urandom_range(2, 12);
         it.dh_im = $signed(it.h_re) >>> $urandom_range(2, 12);
         it.th_re = $signed(24'($urandom)) >>> (sh + $urandom_range(3, 10));
         it.th_im = $signed(24'($urandom)) >>> (sh + $urandom_range(3, 10));
      end else begin
         it.dh_re = rand_field();
         it.dh_im = rand_field();
         it.th_re = rand_field();
         it.th_im = rand_field();
      end
      return it;
   endfunction

   // Timeout guard and cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Record accepted input transactions and predict their results.
   always @(posedge clock) begin
      took <= !reset && req_push && !req_full;
      if (!reset && req_push && !req_full) begin
         expected_results.push_back(reassign_bin(pending_bins[0]));
      end
   end

   // Driver: bursts of random length separated by random gaps.
   int burst_left, gap_left;
   always @(negedge clock) begin
      if (took) void'(pending_bins.pop_front());
      if (reset || (req_push && !took)) begin
         // Hold the current offer until it is accepted.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_push <= 1'b0;
      end else if (pending_bins.size() > 0) begin
         bin_item_type nx;
         nx = pending_bins[0];
         req_push   <= 1'b1;
         req_mode   <= nx.mode;   req_column <= nx.column; req_bin   <= nx.bin;
         req_h_re   <= nx.h_re;   req_h_im   <= nx.h_im;   req_dh_re <= nx.dh_re;
         req_dh_im  <= nx.dh_im;  req_th_re  <= nx.th_re;  req_th_im <= nx.th_im;
         if (burst_left > 0) burst_left <= burst_left - 1;
         else begin
            burst_left <= $urandom_range(0, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else begin
         req_push <= 1'b0;
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off to fill the block.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else if (!long_hold_done && expected_results.size() > 3) begin
         long_hold_done <= 1'b1;
         hold_left      <= 6000;
         rsp_pop        <= 1'b0;
      end else if (cycles % 4096 < 1024) begin
         rsp_pop <= 1'b1;
      end else begin
         rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor: compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d col=%0d bin=%0d power=%0h", $time,
                     rsp_status, rsp_target_column, rsp_target_bin, rsp_power);
            errors++;
         end else begin
            tile_result_type e;
            e = expected_results.pop_front();
            status_seen[e.status]++;
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_target_column !== e.column) begin
               $display("%0t: target_column expected %0d actual %0d", $time, e.column,
                        rsp_target_column);
               errors++;
            end
            if (rsp_target_bin !== e.bin) begin
               $display("%0t: target_bin expected %0d actual %0d", $time, e.bin,
                        rsp_target_bin);
               errors++;
            end
            if (rsp_power !== e.power) begin
               $display("%0t: power expected %0h actual %0h", $time, e.power, rsp_power);
               errors++;
            end
         end
      end
   end

   // Register write over the configuration channel; the predictor follows.
   task automatic csr_write(logic [2:0] idx, logic [47:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_REASSIGN_TIME:   m_reassign_time = value[0];
         CSR_POWER_THRESHOLD: m_threshold     = value;
         CSR_POWER_SHIFT:     m_shift         = value[5:0];
         CSR_INV_STRIDE:      m_inv_stride    = value[16:0];
         CSR_COLUMN_COUNT:    m_column_count  = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_bins.size() != 0 || req_push || expected_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_bin(bit mode, bit [5:0] col, bit [9:0] bn, bit signed [23:0] hr,
                          bit signed [23:0] hi, bit signed [23:0] dr, bit signed [23:0] di,
                          bit signed [23:0] tr, bit signed [23:0] ti);
      pending_bins.push_back('{mode, col, bn, hr, hi, dr, di, tr, ti});
   endtask

   task automatic add_random(int n);
      repeat (n) pending_bins.push_back(random_bin());
   endtask

   // Stimulus: directed cases, then random phases under different settings.
   initial begin
      m_reassign_time = 1'b1;
      m_threshold     = '0;
      m_shift         = 6'd20;
      m_inv_stride    = 17'd65536;
      m_column_count  = 7'd64;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero power, extremes, saturated ratios, wrap, reads.
      add_bin(0, 0, 0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
      add_bin(0, 5, 100, 24'sh400, 0, 0, 0, 0, 0);
      add_bin(1, 5, 612, 0, 0, 0, 0, 0, 0);
      add_bin(0, 63, 1023, -24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608,
              -24'sd8388608, -24'sd8388608);
      add_bin(0, 63, 1023, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh7FFFFF);
      add_bin(0, 10, 0, 1, 0, 0, 24'sh7FFFFF, 0, 0);
      add_bin(0, 10, 0, 1, 0, 0, -24'sd8388608, 0, 0);
      add_bin(0, 0, 1, 24'sh1000, 0, 0, 24'sh0100, -24'sh0400, 0);
      add_bin(0, 3, 1022, 24'sh1000, 0, 0, -24'sh0200, 24'sh0800, 0);
      add_bin(0, 3, 512, 24'sh7FFFFF, 0, 0, 0, 0, 0);
      add_bin(0, 3, 512, 24'sh7FFFFF, 0, 0, 0, 0, 0);
      add_bin(1, 3, 0, 0, 0, 0, 0, 0, 0);
      add_bin(1, 63, 1023, 0, 0, 0, 0, 0, 0);
      add_bin(1, 0, 511, 0, 0, 0, 0, 0, 0);
      add_random(250);
      drain();

      // Frequency-only, no shift, largest stride, fine threshold.
      csr_write(CSR_REASSIGN_TIME, 48'd0);
      csr_write(CSR_POWER_SHIFT, 48'd0);
      csr_write(CSR_INV_STRIDE, 48'd131071);
      csr_write(CSR_POWER_THRESHOLD, 48'h0000_0010_0000);
      add_bin(0, 7, 7, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
      add_bin(0, 7, 7, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
      add_bin(0, 7, 7, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
      add_bin(1, 7, 519, 0, 0, 0, 0, 0, 0);
      add_random(250);
      drain();

      // Time reassignment back on, zero stride, a single column, a shift of 40.
      csr_write(CSR_REASSIGN_TIME, 48'd1);
      csr_write(CSR_INV_STRIDE, 48'd0);
      csr_write(CSR_COLUMN_COUNT, 48'd1);
      csr_write(CSR_POWER_SHIFT, 48'd40);
      csr_write(CSR_POWER_THRESHOLD, 48'd0);
      add_random(200);
      drain();

      // No columns in use, then the largest threshold.
      csr_write(CSR_COLUMN_COUNT, 48'd0);
      add_random(60);
      drain();
      csr_write(CSR_POWER_THRESHOLD, 48'hFFFF_FFFF_FFFF);
      csr_write(CSR_COLUMN_COUNT, 48'd127);
      add_random(60);
      drain();

      // Back to defaults with a mid stride for the last stretch.
      csr_write(CSR_POWER_THRESHOLD, 48'd0);
      csr_write(CSR_POWER_SHIFT, 48'd20);
      csr_write(CSR_INV_STRIDE, 48'd32768);
      csr_write(CSR_COLUMN_COUNT, 48'd64);
      add_random(260);
      drain();

      $display("Covered %0d accumulated, %0d below threshold, %0d outside tile, %0d reads,",
               status_seen[ST_ACCUM], status_seen[ST_LOW], status_seen[ST_OUTSIDE],
               status_seen[ST_READ]);
      $display("over six register settings with bursty input and a long output stall.");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
